@@ sv/qdgg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder package
// Item types, register indexes, event codes and the Gray-code step table
// shared by the decoder core, its step logic and its checker.
// ----------------------------------------------------------------------------
package qdgg_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef logic [CfgIndexW-1:0] cfg_index_t;
  typedef logic [CfgDataW-1:0]  cfg_data_t;

  localparam cfg_index_t CFG_A_POS        = 2'd0;
  localparam cfg_index_t CFG_B_POS        = 2'd1;
  localparam cfg_index_t CFG_MIN_INTERVAL = 2'd2;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_RESYNC = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_STEP   = 3'd1,
    EV_BAD    = 3'd2,
    EV_GLITCH = 3'd3,
    EV_RESYNC = 3'd4
  } event_e;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // Indexed by {previous state, new state}; each state is {A, B}.
  localparam logic signed [1:0] GRAY_STEP [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] port_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic [15:0]        bad_transitions;
    logic [15:0]        rejected_edges;
    logic [2:0]         event_res;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  a_pos;
    logic [2:0]  b_pos;
    logic [15:0] min_interval;
  } cfg_t;

  typedef struct packed {
    logic              take_ab;
    logic [1:0]        next_ab;
    logic signed [1:0] delta;
    logic              err_inc;
    logic              glitch_inc;
    logic              clear_all;
    logic              tick_inc;
    logic              tick_clear;
    event_e            ev;
  } step_t;

endpackage

@@ sv/qdgg_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder step logic
// Decides, for one item, how the position, tallies, tick timer and
// accepted A/B state change, and which event the result reports.
// ----------------------------------------------------------------------------
module qdgg_step (
  input  qdgg_pkg::in_item_t item_i,
  input  qdgg_pkg::cfg_t     cfg_i,
  input  logic [1:0]         accepted_ab_i,
  input  logic [15:0]        ticks_i,
  output qdgg_pkg::step_t    step_o
);
  import qdgg_pkg::*;

  logic [1:0]        now_ab;
  logic              gate_on;
  logic              too_soon;
  logic signed [1:0] gray;

  assign now_ab   = {item_i.port_byte[cfg_i.a_pos], item_i.port_byte[cfg_i.b_pos]};
  assign gate_on  = (cfg_i.min_interval != 16'd0);
  assign too_soon = gate_on && (ticks_i < cfg_i.min_interval);
  assign gray     = GRAY_STEP[{accepted_ab_i, now_ab}];

  always_comb begin
    step_o = '0;
    step_o.next_ab = now_ab;
    step_o.ev      = EV_NONE;
    unique case (item_i.action)
      ACT_SAMPLE: begin
        if (now_ab != accepted_ab_i) begin
          if (too_soon) begin
            step_o.glitch_inc = 1'b1;
            step_o.ev         = EV_GLITCH;
          end else begin
            step_o.take_ab    = 1'b1;
            step_o.tick_clear = gate_on;
            step_o.delta      = gray;
            if (gray == 2'sd0) begin
              step_o.err_inc = 1'b1;
              step_o.ev      = EV_BAD;
            end else begin
              step_o.ev = EV_STEP;
            end
          end
        end
      end
      ACT_TICK: begin
        step_o.tick_inc = (ticks_i != TICKS_MAX);
      end
      ACT_RESYNC: begin
        step_o.clear_all = 1'b1;
        step_o.take_ab   = 1'b1;
        step_o.ev        = EV_RESYNC;
      end
      default: begin
        step_o.ev = EV_NONE;
      end
    endcase
  end

endmodule

@@ sv/quadrature_decoder_glitch_gate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder core with glitch gate
// x4 quadrature decoder fed by port samples, time ticks and resync items,
// returning one counter snapshot per item.
//
//   Channel   Direction   Handshake                  Payload
//   in        input       in_valid_i / in_ready_o    in_item_i  (in_item_t)
//   out       output      out_valid_o / out_ready_i  out_item_o (out_item_t)
//   cfg       input       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle is sustained while results are taken; the rate is set
// by the combinational table lookup and position add between the input and
// result registers, through which each item and then its result pass.
// Reset clears the counters and A/B state, resets the configuration and
// empties both registers; no clearing pass. A stalled result holds the
// result register; the input register still takes one more item behind it.
// ----------------------------------------------------------------------------
module quadrature_decoder_glitch_gate_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  qdgg_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qdgg_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  qdgg_pkg::cfg_index_t cfg_index_i,
  input  qdgg_pkg::cfg_data_t  cfg_data_i
);
  import qdgg_pkg::*;

  in_item_t                  in_q;
  logic                      in_valid_q;
  out_item_t                 out_q, out_d;
  logic                      out_valid_q;
  cfg_t                      cfg_q;
  logic [1:0]                ab_q, ab_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d;
  logic [15:0]               err_q, err_d;
  logic [15:0]               glitch_q, glitch_d;
  logic [15:0]               ticks_q, ticks_d;
  logic                      advance;
  step_t                     step;
  logic signed [31:0]        count_ext;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  qdgg_step u_step (
    .item_i        (in_q),
    .cfg_i         (cfg_q),
    .accepted_ab_i (ab_q),
    .ticks_i       (ticks_q),
    .step_o        (step)
  );

  always_comb begin
    ab_d     = step.take_ab ? step.next_ab : ab_q;
    pos_d    = pos_q + {{(POSITION_BITS-2){step.delta[1]}}, step.delta};
    err_d    = err_q + {15'd0, step.err_inc};
    glitch_d = glitch_q + {15'd0, step.glitch_inc};
    ticks_d  = ticks_q;
    if (step.tick_inc) begin
      ticks_d = ticks_q + 16'd1;
    end
    if (step.tick_clear) begin
      ticks_d = '0;
    end
    if (step.clear_all) begin
      pos_d    = '0;
      err_d    = '0;
      glitch_d = '0;
      ticks_d  = '0;
    end
  end

  if (POSITION_BITS >= 32) begin : g_count_trunc
    assign count_ext = pos_d[31:0];
  end else begin : g_count_sext
    assign count_ext = {{(32-POSITION_BITS){pos_d[POSITION_BITS-1]}}, pos_d};
  end

  always_comb begin
    out_d.count           = count_ext;
    out_d.bad_transitions = err_d;
    out_d.rejected_edges  = glitch_d;
    out_d.event_res       = step.ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ab_q        <= '0;
      pos_q       <= '0;
      err_q       <= '0;
      glitch_q    <= '0;
      ticks_q     <= '0;
      cfg_q.a_pos        <= 3'd0;
      cfg_q.b_pos        <= 3'd1;
      cfg_q.min_interval <= 16'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        ab_q        <= ab_d;
        pos_q       <= pos_d;
        err_q       <= err_d;
        glitch_q    <= glitch_d;
        ticks_q     <= ticks_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_A_POS:        cfg_q.a_pos        <= cfg_data_i[2:0];
          CFG_B_POS:        cfg_q.b_pos        <= cfg_data_i[2:0];
          CFG_MIN_INTERVAL: cfg_q.min_interval <= cfg_data_i;
          default:          cfg_q              <= cfg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

@@ sv/qdgg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder checker
// Port-level checks on the decoder core, attached to it by a bind.
// ----------------------------------------------------------------------------
module qdgg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input qdgg_pkg::out_item_t  out_item_o,
  input logic                 cfg_ready_o
);
  import qdgg_pkg::*;

  // A result that was not transferred stays offered with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // The input side only stalls when a result is waiting and not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A resync result reports cleared counters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_res == EV_RESYNC |->
      out_item_o.count == 32'sd0 && out_item_o.bad_transitions == 16'd0 &&
      out_item_o.rejected_edges == 16'd0)
    else $error("resync result with nonzero counters");

  // Configuration writes are never back-pressured.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind quadrature_decoder_glitch_gate_core qdgg_checker u_qdgg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .cfg_ready_o (cfg_ready_o)
);

@@ tb/sv/tb_quadrature_decoder_glitch_gate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decoder core testbench
// Drives port samples, ticks, resyncs and unused action codes into the
// decoder under several channel mappings and glitch-gate intervals. A
// cycle-free predictor computes the counter snapshot for each transfer, and
// the monitor checks every returned snapshot field by field in order.
// ----------------------------------------------------------------------------
module tb_quadrature_decoder_glitch_gate_core;
  import qdgg_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam cfg_index_t CFG_SPARE   = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;

  // Position of each {A, B} state along the forward rotation 00, 10, 11, 01.
  localparam logic [1:0] PHASE_OF [4] = '{2'd0, 2'd3, 2'd1, 2'd2};

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } feed_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_item   = '0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = '0;
  cfg_data_t  cfg_data  = '0;

  // Predictor state and its copy of the registers.
  logic [2:0]  a_pos_cfg   = 3'd0;
  logic [2:0]  b_pos_cfg   = 3'd1;
  logic [15:0] min_gap_cfg = 16'd0;
  logic [1:0]  ab_state    = 2'b00;
  logic [31:0] position    = '0;
  logic [15:0] bad_cnt     = '0;
  logic [15:0] glitch_cnt  = '0;
  logic [15:0] ticks       = '0;

  feed_t       feed_q[$];
  out_item_t   snapshot_q[$];
  feed_t       next_entry;
  logic        have_next  = 1'b0;
  logic [1:0]  gen_ab     = 2'b00;
  logic        send_lazy  = 1'b0;
  logic        recv_lazy  = 1'b1;
  logic        no_idle    = 1'b0;
  logic        stall_req  = 1'b0;
  logic        recv_hold  = 1'b0;
  int unsigned wait_cycles = 0;
  int unsigned item_total = 0;
  int unsigned result_count = 0;
  int unsigned write_count = 0;
  int unsigned mismatch_count = 0;
  out_item_t   got;
  out_item_t   want;

  quadrature_decoder_glitch_gate_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t decode_item(input in_item_t it);
    logic [1:0] new_ab;
    logic [1:0] turn;
    event_e     ev;
    out_item_t  snap;
    new_ab = {it.port_byte[a_pos_cfg], it.port_byte[b_pos_cfg]};
    ev = EV_NONE;
    case (it.action)
      ACT_SAMPLE: begin
        if (new_ab != ab_state) begin
          if (min_gap_cfg != 16'd0 && ticks < min_gap_cfg) begin
            glitch_cnt = glitch_cnt + 16'd1;
            ev = EV_GLITCH;
          end else begin
            if (min_gap_cfg != 16'd0) ticks = '0;
            turn = PHASE_OF[new_ab] - PHASE_OF[ab_state];
            if (turn == 2'd1) begin
              position = position + 32'd1;
              ev = EV_STEP;
            end else if (turn == 2'd3) begin
              position = position - 32'd1;
              ev = EV_STEP;
            end else begin
              bad_cnt = bad_cnt + 16'd1;
              ev = EV_BAD;
            end
            ab_state = new_ab;
          end
        end
      end
      ACT_TICK: begin
        if (ticks != TICKS_MAX) ticks = ticks + 16'd1;
      end
      ACT_RESYNC: begin
        position = '0;
        bad_cnt = '0;
        glitch_cnt = '0;
        ticks = '0;
        ab_state = new_ab;
        ev = EV_RESYNC;
      end
      default: begin
      end
    endcase
    snap.count = position;
    snap.bad_transitions = bad_cnt;
    snap.rejected_edges = glitch_cnt;
    snap.event_res = ev;
    return snap;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("Mismatch in %s at result %0d: got %0d, expected %0d",
               what, result_count, got_v, want_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && in_ready) snapshot_q.push_back(decode_item(in_item));
      if (!in_valid || in_ready) begin
        if (!have_next && feed_q.size() != 0) begin
          next_entry = feed_q.pop_front();
          have_next = 1'b1;
        end
        if (have_next && next_entry.gap == 0) begin
          in_valid <= 1'b1;
          in_item <= next_entry.item;
          have_next = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (have_next) next_entry.gap = next_entry.gap - 1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        got = out_item;
        if (snapshot_q.size() == 0) begin
          report_mismatch("unexpected result", longint'($signed(got.count)), 0);
        end else begin
          want = snapshot_q.pop_front();
          if (got.count !== want.count)
            report_mismatch("count", longint'($signed(got.count)),
                            longint'($signed(want.count)));
          if (got.bad_transitions !== want.bad_transitions)
            report_mismatch("bad_transitions", longint'(got.bad_transitions),
                            longint'(want.bad_transitions));
          if (got.rejected_edges !== want.rejected_edges)
            report_mismatch("rejected_edges", longint'(got.rejected_edges),
                            longint'(want.rejected_edges));
          if (got.event_res !== want.event_res)
            report_mismatch("event_res", longint'(got.event_res),
                            longint'(want.event_res));
        end
        if (result_count % 64 == 0) recv_lazy = ($urandom_range(2, 0) != 0);
        wait_cycles = (recv_lazy && !no_idle) ? $urandom_range(15, 0) : 0;
      end else if (wait_cycles != 0) begin
        wait_cycles = wait_cycles - 1;
      end
      out_ready <= (wait_cycles == 0) && !recv_hold;
    end
  end

  initial begin
    wait (stall_req);
    @(posedge clk_i);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("Timeout: results still outstanding");
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] port_for(input logic [1:0] ab);
    logic [7:0] p;
    p = 8'($urandom);
    p[a_pos_cfg] = ab[1];
    p[b_pos_cfg] = ab[0];
    return p;
  endfunction

  task automatic push_item(input logic [1:0] act, input logic [7:0] port);
    feed_t e;
    e.item.action = act;
    e.item.port_byte = port;
    e.gap = (send_lazy && !no_idle) ? $urandom_range(15, 0) : 0;
    feed_q.push_back(e);
    item_total++;
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || have_next || in_valid || snapshot_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_A_POS:        a_pos_cfg = data[2:0];
      CFG_B_POS:        b_pos_cfg = data[2:0];
      CFG_MIN_INTERVAL: min_gap_cfg = data;
      default: begin
      end
    endcase
    write_count++;
  endtask

  task automatic configure(input cfg_data_t a, input cfg_data_t b, input cfg_data_t gap);
    wait_idle();
    write_reg(CFG_A_POS, a);
    write_reg(CFG_B_POS, b);
    write_reg(CFG_MIN_INTERVAL, gap);
  endtask

  // Mostly legal encoder motion, with ticks, double flips, resyncs and noise mixed in.
  task automatic gen_motion(input int unsigned n, input int unsigned tick_pct);
    int unsigned roll;
    logic [7:0]  port;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0 && !no_idle) send_lazy = ($urandom_range(2, 0) != 0);
      roll = $urandom_range(99, 0);
      if (roll < tick_pct) begin
        push_item(ACT_TICK, 8'($urandom));
      end else if (roll < tick_pct + 55) begin
        gen_ab = $urandom_range(1, 0) ? {~gen_ab[0], gen_ab[1]} : {gen_ab[0], ~gen_ab[1]};
        push_item(ACT_SAMPLE, port_for(gen_ab));
      end else if (roll < tick_pct + 63) begin
        gen_ab = ~gen_ab;
        push_item(ACT_SAMPLE, port_for(gen_ab));
      end else if (roll < tick_pct + 71) begin
        push_item(ACT_SAMPLE, port_for(gen_ab));
      end else if (roll < tick_pct + 74) begin
        port = 8'($urandom);
        gen_ab = {port[a_pos_cfg], port[b_pos_cfg]};
        push_item(ACT_RESYNC, port);
      end else if (roll < tick_pct + 76) begin
        push_item(ACT_IGNORED, 8'($urandom));
      end else begin
        push_item(ACT_SAMPLE, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(ACT_SAMPLE, 8'h00);
    push_item(ACT_SAMPLE, 8'hFF);
    push_item(ACT_SAMPLE, port_for(2'b01));
    push_item(ACT_SAMPLE, port_for(2'b00));
    push_item(ACT_SAMPLE, port_for(2'b10));
    push_item(ACT_SAMPLE, port_for(2'b11));
    push_item(ACT_SAMPLE, port_for(2'b10));
    push_item(ACT_SAMPLE, port_for(2'b00));
    push_item(ACT_SAMPLE, port_for(2'b01));
    push_item(ACT_SAMPLE, port_for(2'b10));
    push_item(ACT_TICK, 8'hFF);
    push_item(ACT_TICK, 8'h00);
    push_item(ACT_IGNORED, 8'hFF);
    push_item(ACT_IGNORED, 8'h00);
    push_item(ACT_RESYNC, 8'hFF);
    push_item(ACT_SAMPLE, 8'hFC);
    push_item(ACT_SAMPLE, 8'h03);
    push_item(ACT_RESYNC, 8'h00);
    push_item(ACT_SAMPLE, 8'hF0);
    push_item(ACT_SAMPLE, 8'h01);
    gen_ab = 2'b10;
    gen_motion(230, 20);

    configure(16'hFFFF, 16'h0000, 16'h0000);
    gen_motion(220, 20);

    configure(16'd3, 16'hFFFB, 16'h0000);
    write_reg(CFG_SPARE, 16'hFFFF);
    gen_motion(150, 20);

    configure(16'd5, 16'd2, 16'd3);
    push_item(ACT_RESYNC, port_for(2'b00));
    push_item(ACT_SAMPLE, port_for(2'b10));
    push_item(ACT_SAMPLE, port_for(2'b00));
    repeat (3) push_item(ACT_TICK, 8'($urandom));
    push_item(ACT_SAMPLE, port_for(2'b10));
    push_item(ACT_SAMPLE, port_for(2'b11));
    repeat (3) push_item(ACT_TICK, 8'($urandom));
    push_item(ACT_SAMPLE, port_for(2'b01));
    gen_ab = 2'b01;
    gen_motion(300, 40);

    // Hold the glitch gate at its widest interval so that edges are rejected.
    configure(16'd6, 16'd1, 16'hFFFF);
    no_idle = 1'b1;
    push_item(ACT_RESYNC, port_for(2'b00));
    repeat (20) push_item(ACT_TICK, 8'($urandom));
    push_item(ACT_SAMPLE, port_for(2'b10));
    push_item(ACT_SAMPLE, port_for(2'b11));
    wait_idle();
    no_idle = 1'b0;
    gen_ab = 2'b10;
    gen_motion(60, 30);

    configure(16'd0, 16'd7, 16'd1);
    gen_motion(150, 30);
    wait_idle();
    no_idle = 1'b1;
    stall_req = 1'b1;
    gen_motion(200, 25);
    wait_idle();
    no_idle = 1'b0;
    gen_motion(150, 30);

    configure(16'd4, 16'd6, 16'd2);
    gen_motion(200, 35);
    wait_idle();

    $display("Covered %0d items and %0d results over %0d register writes, %0d mismatches",
             item_total, result_count, write_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/qdgg_pkg.sv
sv/qdgg_step.sv
sv/quadrature_decoder_glitch_gate_core.sv
sv/qdgg_checker.sv
tb/sv/tb_quadrature_decoder_glitch_gate_core.sv
